// ===== rtl/lhm_pkg.sv =====
// lhm_pkg: shared types, constants and command structs for the latency histogram monitor
// no dependencies
package lhm_pkg;

  localparam int BIN_COUNT_DEF     = 20;
  localparam int OUTLIER_DEPTH_DEF = 1024;
  localparam int KIND_W            = 2;
  localparam int IDX_W             = 10;
  localparam int BIN_IDX_W         = 5;
  localparam int LIMIT_W           = 11;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 32;

  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_BIN    = 2'd1,
    KIND_RING   = 2'd2,
    KIND_STAT   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_MIN   = 2'd0,
    CFG_KNEE  = 2'd1,
    CFG_OEN   = 2'd2,
    CFG_LIMIT = 2'd3
  } cfg_reg_t;

  localparam logic [IDX_W-1:0] STAT_COUNT = 10'd0;
  localparam logic [IDX_W-1:0] STAT_SUM   = 10'd1;
  localparam logic [IDX_W-1:0] STAT_MIN   = 10'd2;
  localparam logic [IDX_W-1:0] STAT_MAX   = 10'd3;
  localparam logic [IDX_W-1:0] STAT_PTR   = 10'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } lhm_cmd_t;

  // datapath to controller, high while bin bounds are still settling
  typedef struct packed {
    logic busy;
  } lhm_sts_t;

  // saturating multiply of a 64-bit value by 2 or by 10
  function automatic logic [63:0] sat_mul2(input logic [63:0] a);
    sat_mul2 = a[63] ? U64_MAX : {a[62:0], 1'b0};
  endfunction

  function automatic logic [63:0] sat_mul10(input logic [63:0] a);
    logic [67:0] p;
    p = {1'b0, a, 3'b000} + {3'b000, a, 1'b0};
    sat_mul10 = (p[67:64] != 4'd0) ? U64_MAX : p[63:0];
  endfunction

endpackage

// ===== rtl/lhm_ram.sv =====
// lhm_ram: generic single port write, single port registered read memory
// no dependencies
module lhm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/lhm_ctrl.sv =====
// lhm_ctrl: item sequencing state machine
// depends on lhm_pkg
module lhm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  lhm_pkg::lhm_sts_t sts,
  output lhm_pkg::lhm_cmd_t cmd
);
  import lhm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: if (!sts.busy) state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = in_valid ? ST_EXEC : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: cmd.execute = !sts.busy;
      ST_OUT: begin
        out_valid   = 1'b1;
        in_ready    = out_ready;
        cmd.capture = out_ready && in_valid;
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/lhm_dp.sv =====
// lhm_dp: bin bounds, counters, statistics and outlier ring
// depends on lhm_pkg and lhm_ram
module lhm_dp #(
  parameter int BIN_COUNT     = lhm_pkg::BIN_COUNT_DEF,
  parameter int OUTLIER_DEPTH = lhm_pkg::OUTLIER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lhm_pkg::lhm_cmd_t               cmd,
  output lhm_pkg::lhm_sts_t               sts,
  input  logic                            cfg_we,
  input  logic [lhm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lhm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [lhm_pkg::KIND_W-1:0]      in_kind,
  input  logic [63:0]                     in_delta_ticks,
  input  logic [63:0]                     in_sample_time,
  input  logic [lhm_pkg::IDX_W-1:0]       in_read_index,
  output logic [lhm_pkg::BIN_IDX_W-1:0]   out_bin_index,
  output logic                            out_outlier_flag,
  output logic [63:0]                     out_data_primary,
  output logic [63:0]                     out_data_secondary,
  output logic                            out_entry_valid
);
  import lhm_pkg::*;

  localparam int HALF  = BIN_COUNT / 2;
  localparam int BIN_W = $clog2(BIN_COUNT);
  localparam int PTR_W = $clog2(OUTLIER_DEPTH);
  localparam int CNT_W = $clog2(OUTLIER_DEPTH + 1);
  // reciprocal of HALF, exact for any 32-bit dividend
  localparam int          RECIP_SH = 32 + $clog2(HALF);
  localparam logic [32:0] RECIP    = 33'((64'd1 << RECIP_SH) / 64'(HALF) + 64'd1);

  // config
  logic [31:0]        min_r, knee_r;
  logic               oen_r;
  logic [LIMIT_W-1:0] limit_r;

  // bounds follow config, recomputed into registers after every write
  logic [63:0] bound_r [BIN_COUNT];
  logic [63:0] bound_nxt [BIN_COUNT];
  logic [1:0]  pend_r;

  // captured item
  logic [KIND_W-1:0] kind_r;
  logic [63:0]       delta_r, time_r;
  logic [IDX_W-1:0]  ridx_r;

  logic [31:0] bin_cnt_r [BIN_COUNT];
  logic [63:0] count_r, sum_r, smin_r, smax_r;
  logic [PTR_W-1:0] ptr_r;
  logic             wrap_r;
  logic [CNT_W-1:0] fill_r;

  logic [BIN_IDX_W-1:0] obin_r;
  logic                 oflag_r;
  logic [63:0]          prim_r, sec_r;
  logic                 evalid_r, ring_rd_r;

  // busy from a config write or reset until the bounds have passed the first-stage and bound registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd2;
    end else if (cfg_we) begin
      pend_r <= 2'd2;
    end else if (pend_r != 2'd0) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  assign sts.busy = (pend_r != 2'd0);

  // first stage: linear span and its quotient by HALF
  logic [31:0] span_a, quo_a, span_r, quo_r;
  logic [64:0] recip_prod;
  assign span_a     = (knee_r > min_r) ? knee_r - min_r : 32'd0;
  assign recip_prod = {33'd0, span_a} * {32'd0, RECIP};
  assign quo_a      = 32'(recip_prod >> RECIP_SH);

  always_ff @(posedge clk) begin
    span_r <= span_a;
    quo_r  <= quo_a;
  end

  // second stage: span*(i+1)/HALF as quotient*(i+1) plus the spread remainder
  always_comb begin
    logic [31:0] rem, part;
    logic [63:0] frac, mult;
    rem = span_r - quo_r * 32'(HALF);
    for (int i = 0; i < HALF; i++) begin
      part = rem * 32'(i + 1);
      frac = 64'd0;
      for (int k = 1; k < HALF; k++) begin
        if (part >= 32'(k * HALF)) frac = 64'(k);
      end
      bound_nxt[i] = {32'd0, min_r} + {32'd0, quo_r} * 64'(i + 1) + frac;
    end
    mult = {32'd0, knee_r};
    for (int j = 0; HALF + j < BIN_COUNT; j++) begin
      if ((j & 1) == 0) begin
        bound_nxt[HALF + j] = sat_mul2(mult);
      end else begin
        mult = sat_mul10(mult);
        bound_nxt[HALF + j] = mult;
      end
    end
    bound_nxt[BIN_COUNT-1] = U64_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= 32'd30;
      knee_r  <= 32'd50;
      oen_r   <= 1'b0;
      limit_r <= LIMIT_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MIN:   min_r   <= cfg_data;
        CFG_KNEE:  knee_r  <= cfg_data;
        CFG_OEN:   oen_r   <= cfg_data[0];
        CFG_LIMIT: limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BIN_COUNT; i++) bound_r[i] <= bound_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      delta_r <= in_delta_ticks;
      time_r  <= in_sample_time;
      ridx_r  <= in_read_index;
    end
  end

  // parallel compare, first bin whose bound covers the sample
  logic [BIN_W-1:0] hit;
  always_comb begin
    hit = BIN_W'(BIN_COUNT - 1);
    for (int i = BIN_COUNT - 2; i >= 0; i--) begin
      if (delta_r <= bound_r[i]) hit = BIN_W'(i);
    end
  end

  logic rec, is_out, ring_we;
  logic [CNT_W-1:0] lim_eff, ptr_inc;
  assign rec     = cmd.execute && (kind_t'(kind_r) == KIND_RECORD);
  assign is_out  = oen_r && (delta_r > {32'd0, knee_r});
  assign ring_we = rec && is_out;
  always_comb begin
    if (limit_r == '0) lim_eff = CNT_W'(1);
    else if (32'(limit_r) > OUTLIER_DEPTH) lim_eff = CNT_W'(OUTLIER_DEPTH);
    else lim_eff = CNT_W'(limit_r);
  end
  assign ptr_inc = CNT_W'(ptr_r) + CNT_W'(1);

  // ring entries are written from 0 upward, so written ones lie below the fill count
  logic [63:0] rd_time, rd_delta;
  logic        idx_in_ring, idx_written;
  assign idx_in_ring = 32'(ridx_r) < OUTLIER_DEPTH;
  assign idx_written = 32'(ridx_r) < 32'(fill_r);

  lhm_ram #(.WIDTH(64), .DEPTH(OUTLIER_DEPTH)) u_time (
    .clk, .we(ring_we), .waddr(ptr_r), .wdata(time_r),
    .raddr(PTR_W'(ridx_r)), .rdata(rd_time)
  );
  lhm_ram #(.WIDTH(64), .DEPTH(OUTLIER_DEPTH)) u_delta (
    .clk, .we(ring_we), .waddr(ptr_r), .wdata(delta_r),
    .raddr(PTR_W'(ridx_r)), .rdata(rd_delta)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BIN_COUNT; i++) bin_cnt_r[i] <= '0;
      count_r <= '0;
      sum_r   <= '0;
      smin_r  <= U64_MAX;
      smax_r  <= '0;
      ptr_r   <= '0;
      wrap_r  <= 1'b0;
      fill_r  <= '0;
    end else if (rec) begin
      if (bin_cnt_r[hit] != U32_MAX) bin_cnt_r[hit] <= bin_cnt_r[hit] + 32'd1;
      count_r <= count_r + 64'd1;
      sum_r   <= sum_r + delta_r;
      if (delta_r < smin_r) smin_r <= delta_r;
      if (delta_r > smax_r) smax_r <= delta_r;
      if (is_out) begin
        if (ptr_inc > fill_r) fill_r <= ptr_inc;
        if (ptr_inc >= lim_eff) begin
          ptr_r  <= '0;
          wrap_r <= 1'b1;
        end else begin
          ptr_r <= ptr_inc[PTR_W-1:0];
        end
      end
    end
  end

  // result assembly; ring read data comes straight from the ram read register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      obin_r    <= '0;
      oflag_r   <= 1'b0;
      prim_r    <= '0;
      sec_r     <= '0;
      evalid_r  <= 1'b0;
      ring_rd_r <= 1'b0;
      unique case (kind_t'(kind_r))
        KIND_RECORD: begin
          obin_r  <= BIN_IDX_W'(hit);
          oflag_r <= is_out;
        end
        KIND_BIN: begin
          if (32'(ridx_r) < BIN_COUNT) prim_r <= {32'd0, bin_cnt_r[ridx_r[BIN_W-1:0]]};
        end
        KIND_RING: begin
          evalid_r  <= idx_in_ring && idx_written;
          ring_rd_r <= idx_in_ring && idx_written;
        end
        KIND_STAT: begin
          priority case (ridx_r)
            STAT_COUNT: prim_r <= count_r;
            STAT_SUM:   prim_r <= sum_r;
            STAT_MIN:   prim_r <= smin_r;
            STAT_MAX:   prim_r <= smax_r;
            STAT_PTR: begin
              prim_r <= 64'(ptr_r);
              sec_r  <= {63'd0, wrap_r};
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign out_bin_index      = obin_r;
  assign out_outlier_flag   = oflag_r;
  assign out_data_primary   = ring_rd_r ? rd_time  : prim_r;
  assign out_data_secondary = ring_rd_r ? rd_delta : sec_r;
  assign out_entry_valid    = evalid_r;
endmodule

// ===== rtl/latency_histogram_monitor.sv =====
// latency_histogram_monitor: top level, controller plus datapath
// depends on lhm_pkg, lhm_ctrl, lhm_dp
//
//  channel | ports                          | accepted when
//  in      | in_valid/in_ready, 4 fields    | in_valid && in_ready
//  out     | out_valid/out_ready, 5 fields  | out_valid && out_ready
//  cfg     | cfg_we, cfg_index, cfg_data    | cfg_we
//
// an item goes through capture, then bin compare and counter update,
// and the result register holds it until taken; a new item is taken in the
// same cycle the result leaves. ring reads come from the ram read register.
// reset is synchronous; the outlier ram holds no reset, a fill count covers it.
// bin bounds settle through the first-stage and bound registers after a config
// write or reset; an item that reaches execute earlier waits there until they have.
module latency_histogram_monitor #(
  parameter int BIN_COUNT     = lhm_pkg::BIN_COUNT_DEF,
  parameter int OUTLIER_DEPTH = lhm_pkg::OUTLIER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lhm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lhm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lhm_pkg::KIND_W-1:0]      in_kind,
  input  logic [63:0]                     in_delta_ticks,
  input  logic [63:0]                     in_sample_time,
  input  logic [lhm_pkg::IDX_W-1:0]       in_read_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lhm_pkg::BIN_IDX_W-1:0]   out_bin_index,
  output logic                            out_outlier_flag,
  output logic [63:0]                     out_data_primary,
  output logic [63:0]                     out_data_secondary,
  output logic                            out_entry_valid
);
  import lhm_pkg::*;

  lhm_cmd_t cmd;
  lhm_sts_t sts;

  lhm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  lhm_dp #(.BIN_COUNT(BIN_COUNT), .OUTLIER_DEPTH(OUTLIER_DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_index, .cfg_data,
    .in_kind, .in_delta_ticks, .in_sample_time, .in_read_index,
    .out_bin_index, .out_outlier_flag, .out_data_primary,
    .out_data_secondary, .out_entry_valid
  );
endmodule

// ===== rtl/lhm_checker.sv =====
// lhm_checker: port level checks of the monitor, bound to the top level
// depends on lhm_pkg
module lhm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_data_primary,
  input logic        out_outlier_flag,
  input logic        out_entry_valid
);
  import lhm_pkg::*;

  // one result per item, so a taken result is never shown again next cycle
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("result repeated");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_primary))
    else $error("result dropped while stalled");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while result stalled");

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_outlier_flag && out_entry_valid))
    else $error("record and ring read flags together");
endmodule

bind latency_histogram_monitor lhm_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_data_primary, .out_outlier_flag, .out_entry_valid
);
